FILE: rtl/telecontrol_link_sequence_window_macros.svh
// Assertion helpers shared by the session controller modules.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef TELECONTROL_LINK_SEQUENCE_WINDOW_MACROS_SVH
`define TELECONTROL_LINK_SEQUENCE_WINDOW_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TLSW_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TLSW_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/tlsw_pkg.sv
package tlsw_pkg;

  localparam int SEQ_W  = 15;
  localparam int KIND_W = 4;
  localparam int FUNC_W = 3;
  localparam int CMD_W  = 3;
  localparam int TMR_W  = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;

  typedef logic [SEQ_W-1:0]  seq_t;
  typedef logic [FUNC_W-1:0] func_t;
  typedef logic [KIND_W-1:0] kind_t;
  typedef logic [CMD_W-1:0]  cmd_t;

  // Input event codes.
  localparam cmd_t CMD_RX_I    = 3'd0;
  localparam cmd_t CMD_RX_S    = 3'd1;
  localparam cmd_t CMD_RX_U    = 3'd2;
  localparam cmd_t CMD_TX_REQ  = 3'd3;
  localparam cmd_t CMD_TICK    = 3'd4;
  localparam cmd_t CMD_CONNECT = 3'd5;

  // U frame functions.
  localparam func_t FN_STARTACT = 3'd0;
  localparam func_t FN_STARTCON = 3'd1;
  localparam func_t FN_STOPACT  = 3'd2;
  localparam func_t FN_STOPCON  = 3'd3;
  localparam func_t FN_TESTACT  = 3'd4;
  localparam func_t FN_TESTCON  = 3'd5;

  // Result kinds.
  localparam kind_t KIND_SEND_I = 4'd0;
  localparam kind_t KIND_SEND_S = 4'd1;
  localparam kind_t KIND_SEND_U = 4'd2;
  localparam kind_t KIND_DATA   = 4'd3;
  localparam kind_t KIND_WAKE   = 4'd4;
  localparam kind_t KIND_ACT    = 4'd5;
  localparam kind_t KIND_DEACT  = 4'd6;
  localparam kind_t KIND_CLOSE  = 4'd7;
  localparam kind_t KIND_REFUSE = 4'd8;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_IS_MASTER    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_TIMEOUT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_DELAY    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TIMEOUT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SEND_WINDOW  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_WINDOW   = 3'd5;

  localparam logic [TMR_W-1:0] RST_ACK_TIMEOUT  = 8'd15;
  localparam logic [TMR_W-1:0] RST_ACK_DELAY    = 8'd10;
  localparam logic [TMR_W-1:0] RST_IDLE_TIMEOUT = 8'd20;
  localparam seq_t             RST_SEND_WINDOW  = 15'd12;
  localparam seq_t             RST_ACK_WINDOW   = 15'd8;

  // One input event gives at most three result beats.
  localparam logic [1:0] MAX_RES = 2'd3;

  typedef struct packed {
    logic             is_master;
    logic [TMR_W-1:0] ack_timeout;
    logic [TMR_W-1:0] ack_delay;
    logic [TMR_W-1:0] idle_timeout;
    seq_t             send_window;
    seq_t             ack_window;
  } cfg_t;

  typedef struct packed {
    logic [TMR_W-1:0] count;
    logic             run;
  } timer_t;

  typedef struct packed {
    seq_t   send_count;
    seq_t   recv_count;
    seq_t   acked_count;
    seq_t   peer_acked_count;
    logic   stopped;
    logic   test_pending;
    timer_t ack_timer;
    timer_t delay_timer;
    timer_t idle_timer;
  } sess_t;

  typedef struct packed {
    kind_t kind;
    seq_t  send_seq;
    seq_t  recv_seq;
    func_t func;
  } res_t;

  // All results of one event, in order; cnt is how many are valid.
  typedef struct packed {
    res_t [2:0] res;
    logic [1:0] cnt;
  } bundle_t;

endpackage

FILE: rtl/tlsw_front.sv
module tlsw_front (
  input  logic            clk,
  input  logic            rst_n,
  input  tlsw_pkg::cfg_t  cfg,
  input  logic            in_valid,
  output logic            in_stall,
  input  tlsw_pkg::cmd_t  in_cmd,
  input  tlsw_pkg::seq_t  in_rx_send_seq,
  input  tlsw_pkg::seq_t  in_rx_recv_seq,
  input  tlsw_pkg::func_t in_rx_func,
  input  logic            q_full,
  output logic            push,
  output tlsw_pkg::bundle_t push_data
);
  import tlsw_pkg::*;

  `include "telecontrol_link_sequence_window_macros.svh"

  localparam sess_t SESS_RST = '{
    send_count: '0, recv_count: '0, acked_count: '0, peer_acked_count: '0,
    stopped: 1'b1, test_pending: 1'b0,
    ack_timer: '0, delay_timer: '0, idle_timer: '0
  };

  function automatic bundle_t add_res(bundle_t b, kind_t k, seq_t ns, seq_t nr, func_t fn);
    bundle_t r;
    r = b;
    if (r.cnt != MAX_RES) begin
      r.res[r.cnt].kind     = k;
      r.res[r.cnt].send_seq = ns;
      r.res[r.cnt].recv_seq = nr;
      r.res[r.cnt].func     = fn;
      r.cnt                 = r.cnt + 2'd1;
    end
    return r;
  endfunction

  function automatic timer_t tmr_start(logic [TMR_W-1:0] v);
    timer_t t;
    t.count = v;
    t.run   = 1'b1;
    return t;
  endfunction

  // A running timer expires on the tick that finds it at one or zero.
  function automatic logic tmr_due(timer_t t);
    return t.run && (t.count <= 8'd1);
  endfunction

  function automatic timer_t tmr_dec(timer_t t);
    timer_t r;
    r = t;
    if (t.run) begin
      r.count = t.count - 8'd1;
    end
    return r;
  endfunction

  sess_t   sess_r;
  sess_t   sess_nxt;
  bundle_t bnd;
  logic    accept;
  logic    ctl_stopped;
  seq_t    ack_span;
  seq_t    nr_span;
  seq_t    recv_inc;
  seq_t    unacked_in;
  logic    bad_ack;
  logic    ack_all;

  assign in_stall    = q_full;
  assign accept      = in_valid && !q_full;
  assign ctl_stopped = !cfg.is_master && sess_r.stopped;
  assign ack_span    = sess_r.send_count - sess_r.acked_count;
  assign nr_span     = in_rx_recv_seq - sess_r.acked_count;
  assign bad_ack     = nr_span > ack_span;
  assign ack_all     = in_rx_recv_seq == sess_r.send_count;
  assign recv_inc    = sess_r.recv_count + 15'd1;
  assign unacked_in  = recv_inc - sess_r.peer_acked_count;

  always_comb begin
    sess_nxt = sess_r;
    bnd      = '0;
    if (accept) begin
      unique case (in_cmd)
        CMD_RX_I: begin
          sess_nxt.idle_timer = tmr_start(cfg.idle_timeout);
          if (!ctl_stopped) begin
            if (bad_ack) begin
              bnd      = add_res(bnd, KIND_CLOSE, '0, '0, '0);
              sess_nxt = SESS_RST;
            end else begin
              sess_nxt.acked_count = in_rx_recv_seq;
              if (ack_all) begin
                sess_nxt.ack_timer = '0;
                bnd = add_res(bnd, KIND_WAKE, '0, '0, '0);
              end
              sess_nxt.delay_timer = tmr_start(cfg.ack_delay);
              if (in_rx_send_seq != sess_r.recv_count) begin
                bnd      = add_res(bnd, KIND_CLOSE, '0, '0, '0);
                sess_nxt = SESS_RST;
              end else begin
                sess_nxt.recv_count = recv_inc;
                if (unacked_in == cfg.ack_window) begin
                  bnd = add_res(bnd, KIND_SEND_S, '0, recv_inc, '0);
                  sess_nxt.peer_acked_count = recv_inc;
                end
                bnd = add_res(bnd, KIND_DATA, in_rx_send_seq, '0, '0);
              end
            end
          end
        end
        CMD_RX_S: begin
          sess_nxt.idle_timer = tmr_start(cfg.idle_timeout);
          if (bad_ack) begin
            bnd      = add_res(bnd, KIND_CLOSE, '0, '0, '0);
            sess_nxt = SESS_RST;
          end else begin
            sess_nxt.acked_count = in_rx_recv_seq;
            if (ack_all) begin
              sess_nxt.ack_timer = '0;
              bnd = add_res(bnd, KIND_WAKE, '0, '0, '0);
            end
          end
        end
        CMD_RX_U: begin
          sess_nxt.idle_timer = tmr_start(cfg.idle_timeout);
          unique case (in_rx_func)
            FN_STARTACT: begin
              if (cfg.is_master) begin
                bnd      = add_res(bnd, KIND_CLOSE, '0, '0, '0);
                sess_nxt = SESS_RST;
              end else begin
                sess_nxt.stopped = 1'b0;
                bnd = add_res(bnd, KIND_SEND_U, '0, '0, FN_STARTCON);
                bnd = add_res(bnd, KIND_ACT, '0, '0, '0);
              end
            end
            FN_STARTCON: begin
              if (!cfg.is_master) begin
                bnd      = add_res(bnd, KIND_CLOSE, '0, '0, '0);
                sess_nxt = SESS_RST;
              end else begin
                sess_nxt.ack_timer = '0;
                sess_nxt.stopped   = 1'b0;
                bnd = add_res(bnd, KIND_ACT, '0, '0, '0);
              end
            end
            FN_STOPACT: begin
              if (cfg.is_master) begin
                bnd      = add_res(bnd, KIND_CLOSE, '0, '0, '0);
                sess_nxt = SESS_RST;
              end else begin
                sess_nxt.stopped = 1'b1;
                bnd = add_res(bnd, KIND_SEND_U, '0, '0, FN_STOPCON);
                bnd = add_res(bnd, KIND_DEACT, '0, '0, '0);
              end
            end
            FN_STOPCON: begin
              if (!cfg.is_master) begin
                bnd      = add_res(bnd, KIND_CLOSE, '0, '0, '0);
                sess_nxt = SESS_RST;
              end else begin
                sess_nxt.stopped = 1'b1;
                bnd = add_res(bnd, KIND_DEACT, '0, '0, '0);
              end
            end
            FN_TESTACT: begin
              bnd = add_res(bnd, KIND_SEND_U, '0, '0, FN_TESTCON);
              if (!cfg.is_master && !sess_r.test_pending) begin
                sess_nxt.idle_timer = '0;
              end
            end
            FN_TESTCON: begin
              if (!sess_r.test_pending) begin
                bnd      = add_res(bnd, KIND_CLOSE, '0, '0, '0);
                sess_nxt = SESS_RST;
              end else begin
                sess_nxt.ack_timer    = '0;
                sess_nxt.test_pending = 1'b0;
              end
            end
            default: begin
            end
          endcase
        end
        CMD_TX_REQ: begin
          if (ctl_stopped || (ack_span >= cfg.send_window)) begin
            bnd = add_res(bnd, KIND_REFUSE, '0, '0, '0);
          end else begin
            bnd = add_res(bnd, KIND_SEND_I, sess_r.send_count, sess_r.recv_count, '0);
            sess_nxt.ack_timer  = tmr_start(cfg.ack_timeout);
            sess_nxt.send_count = sess_r.send_count + 15'd1;
          end
        end
        CMD_TICK: begin
          if (tmr_due(sess_r.ack_timer)) begin
            bnd      = add_res(bnd, KIND_CLOSE, '0, '0, '0);
            sess_nxt = SESS_RST;
          end else begin
            sess_nxt.ack_timer = tmr_dec(sess_r.ack_timer);
            if (tmr_due(sess_r.delay_timer)) begin
              sess_nxt.delay_timer      = '0;
              sess_nxt.peer_acked_count = sess_r.recv_count;
              bnd = add_res(bnd, KIND_SEND_S, '0, sess_r.recv_count, '0);
            end else begin
              sess_nxt.delay_timer = tmr_dec(sess_r.delay_timer);
            end
            if (tmr_due(sess_r.idle_timer)) begin
              sess_nxt.idle_timer   = '0;
              sess_nxt.ack_timer    = tmr_start(cfg.ack_timeout);
              sess_nxt.test_pending = 1'b1;
              bnd = add_res(bnd, KIND_SEND_U, '0, '0, FN_TESTACT);
            end else begin
              sess_nxt.idle_timer = tmr_dec(sess_r.idle_timer);
            end
          end
        end
        CMD_CONNECT: begin
          sess_nxt = SESS_RST;
          if (cfg.is_master) begin
            bnd = add_res(bnd, KIND_SEND_U, '0, '0, FN_STARTACT);
            sess_nxt.ack_timer = tmr_start(cfg.ack_timeout);
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign push      = accept && (bnd.cnt != 2'd0);
  assign push_data = bnd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sess_r <= SESS_RST;
    end else begin
      sess_r <= sess_nxt;
    end
  end

  // An expiring t1 ends the session and closes alone.
  `TLSW_ASSERT_IMP(a_t1_close_alone,
    accept && (in_cmd == CMD_TICK) && sess_r.ack_timer.run && (sess_r.ack_timer.count <= 8'd1),
    push && (push_data.cnt == 2'd1) && (push_data.res[0].kind == KIND_CLOSE),
    "t1 expiry did not give a single close")
  // A transmit request always gives exactly one beat: a stamped I frame or a refusal.
  `TLSW_ASSERT_IMP(a_tx_one_beat, accept && (in_cmd == CMD_TX_REQ),
    push && (push_data.cnt == 2'd1), "tx request did not give one beat")

endmodule

FILE: rtl/tlsw_fifo.sv
module tlsw_fifo #(
  parameter int DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  tlsw_pkg::bundle_t din,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output tlsw_pkg::bundle_t head
);
  import tlsw_pkg::*;

  `include "telecontrol_link_sequence_window_macros.svh"

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  bundle_t            mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r;
  logic [PTR_W-1:0]   wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic [PTR_W-1:0]   rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r;
  logic [CNT_W-1:0]   count_nxt;

  assign full       = count_r == CNT_W'(DEPTH);
  assign head_valid = count_r != '0;
  assign head       = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // A lone write that finds room grows the occupancy by one.
  `TLSW_ASSERT_NXT(a_fifo_grow, push && !pop && !full,
    count_r == CNT_W'($past(count_r) + 1'b1), "queue occupancy did not grow")

endmodule

FILE: rtl/tlsw_back.sv
module tlsw_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              head_valid,
  input  tlsw_pkg::bundle_t head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output tlsw_pkg::kind_t   out_kind,
  output tlsw_pkg::seq_t    out_send_seq,
  output tlsw_pkg::seq_t    out_recv_seq,
  output tlsw_pkg::func_t   out_func,
  output logic              out_last
);
  import tlsw_pkg::*;

  `include "telecontrol_link_sequence_window_macros.svh"

  logic [1:0] idx_r;
  logic [1:0] idx_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  res_t       beat_r;
  logic       last_r;
  logic       load;
  logic       last_beat;

  assign load      = head_valid && (!out_valid_r || !out_stall);
  assign last_beat = idx_r == (head.cnt - 2'd1);
  assign pop       = load && last_beat;

  always_comb begin
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (load) begin
      out_valid_nxt = 1'b1;
      idx_nxt       = last_beat ? 2'd0 : idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      beat_r <= head.res[idx_r];
      last_r <= last_beat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_kind     = beat_r.kind;
  assign out_send_seq = beat_r.send_seq;
  assign out_recv_seq = beat_r.recv_seq;
  assign out_func     = beat_r.func;
  assign out_last     = last_r;

  // Only events with results are queued, so a queued bundle is never empty.
  `TLSW_ASSERT_IMP(a_head_not_empty, head_valid, head.cnt != 2'd0,
    "empty result bundle reached the output side")

endmodule

FILE: rtl/telecontrol_link_sequence_window.sv
// Link session controller for a 104-style telecontrol connection.
// The input channel (in_valid/in_stall) carries one event per beat: a decoded
// received I, S or U frame, a transmit request, a one-second tick or a connect.
// The output channel (out_valid/out_stall) carries one result per beat: a frame
// to send or an indication to the user; out_last marks the final beat of an event.
// An event may give no result, or one to three beats.
// The front end updates the sequence numbers, flags and timers in the cycle
// the event is accepted and files all of its results as one bundle in a short
// queue; the back end plays bundles out from an output register, one beat per
// cycle while the receiver does not stall. A beat passes the queue and then the
// output register. Throughput: one event per cycle while each event gives at
// most one beat and nothing stalls; an event with n results takes n output beats,
// which bounds the sustained rate. in_stall rises only when the queue of QDEPTH
// bundles is full. When the receiver stalls, the beat held on the output stays put,
// the queue fills, and then the input is stalled; nothing is lost or repeated.
// Reset (synchronous, active low) clears the session to stopped with all
// sequence numbers zero and all timers stopped, empties the queue and loads the
// default configuration. Configuration registers are written through cfg_we,
// cfg_index and cfg_wdata and must only change while the block is idle.
module telecontrol_link_sequence_window #(
  parameter int QDEPTH = 2
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_we,
  input  logic [tlsw_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [tlsw_pkg::CFG_DATA_W-1:0]        cfg_wdata,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  tlsw_pkg::cmd_t                         in_cmd,
  input  tlsw_pkg::seq_t                         in_rx_send_seq,
  input  tlsw_pkg::seq_t                         in_rx_recv_seq,
  input  tlsw_pkg::func_t                        in_rx_func,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output tlsw_pkg::kind_t                        out_kind,
  output tlsw_pkg::seq_t                         out_send_seq,
  output tlsw_pkg::seq_t                         out_recv_seq,
  output tlsw_pkg::func_t                        out_func,
  output logic                                   out_last
);
  import tlsw_pkg::*;

  // Configuration registers; the session logic reads them as one struct.
  cfg_t    cfg_r;
  cfg_t    cfg_nxt;
  logic    q_full;
  logic    q_push;
  bundle_t q_din;
  logic    q_pop;
  logic    q_head_valid;
  bundle_t q_head;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_IS_MASTER:    cfg_nxt.is_master    = cfg_wdata[0];
        CFG_ACK_TIMEOUT:  cfg_nxt.ack_timeout  = cfg_wdata[TMR_W-1:0];
        CFG_ACK_DELAY:    cfg_nxt.ack_delay    = cfg_wdata[TMR_W-1:0];
        CFG_IDLE_TIMEOUT: cfg_nxt.idle_timeout = cfg_wdata[TMR_W-1:0];
        CFG_SEND_WINDOW:  cfg_nxt.send_window  = cfg_wdata[SEQ_W-1:0];
        CFG_ACK_WINDOW:   cfg_nxt.ack_window   = cfg_wdata[SEQ_W-1:0];
        default: begin
          // Writes to unused indexes are dropped.
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.is_master    <= 1'b0;
      cfg_r.ack_timeout  <= RST_ACK_TIMEOUT;
      cfg_r.ack_delay    <= RST_ACK_DELAY;
      cfg_r.idle_timeout <= RST_IDLE_TIMEOUT;
      cfg_r.send_window  <= RST_SEND_WINDOW;
      cfg_r.ack_window   <= RST_ACK_WINDOW;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Front end: takes events and runs the session state machine.
  tlsw_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_cmd         (in_cmd),
    .in_rx_send_seq (in_rx_send_seq),
    .in_rx_recv_seq (in_rx_recv_seq),
    .in_rx_func     (in_rx_func),
    .q_full         (q_full),
    .push           (q_push),
    .push_data      (q_din)
  );

  // Queue of result bundles between the two sides.
  tlsw_fifo #(
    .DEPTH (QDEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .din        (q_din),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head       (q_head)
  );

  // Back end: splits each bundle into output beats.
  tlsw_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head_valid   (q_head_valid),
    .head         (q_head),
    .pop          (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_kind     (out_kind),
    .out_send_seq (out_send_seq),
    .out_recv_seq (out_recv_seq),
    .out_func     (out_func),
    .out_last     (out_last)
  );

endmodule

FILE: bench/tb_telecontrol_link_sequence_window.sv
module tb_telecontrol_link_sequence_window;
  timeunit 1ns;
  timeprecision 1ps;

  import tlsw_pkg::*;

  // The run is stopped here whatever happens.
  localparam int LIMIT_CYCLES = 500000;
  // Time allowed for the block to settle before a register write and at the end.
  localparam int SETTLE_CYCLES = 12;

  // Event and function codes that the package leaves unnamed. The block gives no result for them.
  localparam cmd_t  CMD_SPARE_LO = 3'd6;
  localparam cmd_t  CMD_SPARE_HI = 3'd7;
  localparam func_t FN_SPARE     = 3'd7;

  // One input event. When shaped is set, the driver fills in N(S) and N(R) from the
  // session state at the moment the beat is presented, so that the frame is in order.
  typedef struct {
    cmd_t  cmd;
    seq_t  ns;
    seq_t  nr;
    func_t fn;
    bit    shaped;
  } link_evt_t;

  // One result beat as the output channel should carry it.
  typedef struct {
    kind_t kind;
    seq_t  send_seq;
    seq_t  recv_seq;
    func_t func;
    bit    last;
  } beat_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  cmd_t                  in_cmd = '0;
  seq_t                  in_rx_send_seq = '0;
  seq_t                  in_rx_recv_seq = '0;
  func_t                 in_rx_func = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  kind_t                 out_kind;
  seq_t                  out_send_seq;
  seq_t                  out_recv_seq;
  func_t                 out_func;
  logic                  out_last;

  telecontrol_link_sequence_window uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_cmd         (in_cmd),
    .in_rx_send_seq (in_rx_send_seq),
    .in_rx_recv_seq (in_rx_recv_seq),
    .in_rx_func     (in_rx_func),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_kind       (out_kind),
    .out_send_seq   (out_send_seq),
    .out_recv_seq   (out_recv_seq),
    .out_func       (out_func),
    .out_last       (out_last)
  );

  // Session mirror: configuration, sequence numbers, flags and the three timers.
  cfg_t   link_cfg;
  seq_t   send_cnt;
  seq_t   recv_cnt;
  seq_t   acked_cnt;
  seq_t   peer_acked_cnt;
  bit     stopped;
  bit     test_pend;
  timer_t t1_ack;
  timer_t t2_delay;
  timer_t t3_idle;

  link_evt_t   pending[$];        // events waiting for the driver
  beat_t       awaited_beats[$];  // result beats predicted but not yet seen
  beat_t       event_beats[$];    // beats of the event being predicted
  link_evt_t   cur_evt;
  int unsigned pushed_cnt = 0;
  int unsigned accepted_cnt = 0;
  int unsigned err_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned calm_left[2] = '{0, 0};

  initial begin
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Session predictor
  // ---------------------------------------------------------------------------

  // Distance from b up to a, modulo the sequence space. The 15-bit result wraps.
  function automatic seq_t seq_dist(seq_t a, seq_t b);
    return a - b;
  endfunction

  function automatic timer_t tmr_load(logic [TMR_W-1:0] secs);
    timer_t t;
    t.count = secs;
    t.run = 1'b1;
    return t;
  endfunction

  // A running timer fires on the tick that finds it at one or zero.
  function automatic bit tmr_due(timer_t t);
    return t.run && (t.count <= 1);
  endfunction

  function automatic timer_t tmr_tick(timer_t t);
    timer_t n;
    n = t;
    if (t.run) begin
      if (t.count <= 1) n = '0;
      else n.count = t.count - 1'b1;
    end
    return n;
  endfunction

  // No event gives more than three beats; anything past that is dropped.
  function automatic void note(kind_t kind, seq_t ns, seq_t nr, func_t fn);
    beat_t b;
    if (event_beats.size() < 3) begin
      b.kind = kind;
      b.send_seq = ns;
      b.recv_seq = nr;
      b.func = fn;
      b.last = 1'b0;
      event_beats.push_back(b);
    end
  endfunction

  function automatic void clear_session();
    send_cnt = '0;
    recv_cnt = '0;
    acked_cnt = '0;
    peer_acked_cnt = '0;
    stopped = 1'b1;
    test_pend = 1'b0;
    t1_ack = '0;
    t2_delay = '0;
    t3_idle = '0;
  endfunction

  function automatic void close_session();
    note(KIND_CLOSE, '0, '0, '0);
    clear_session();
  endfunction

  // Takes a received N(R). An acknowledgement outside acked..send closes the
  // session, and the caller must then stop working on the frame.
  function automatic bit take_ack(seq_t nr);
    if (seq_dist(nr, acked_cnt) > seq_dist(send_cnt, acked_cnt)) begin
      close_session();
      return 1'b0;
    end
    acked_cnt = nr;
    if (acked_cnt == send_cnt) begin
      t1_ack = '0;
      note(KIND_WAKE, '0, '0, '0);
    end
    return 1'b1;
  endfunction

  function automatic void predict_event(link_evt_t e);
    beat_t tail;
    event_beats.delete();
    case (e.cmd)
      CMD_RX_I: begin
        t3_idle = tmr_load(link_cfg.idle_timeout);
        // A stopped controlled station drops I frames silently.
        if (link_cfg.is_master || !stopped) begin
          if (take_ack(e.nr)) begin
            t2_delay = tmr_load(link_cfg.ack_delay);
            if (e.ns != recv_cnt) begin
              close_session();
            end else begin
              recv_cnt = recv_cnt + 1'b1;
              if (seq_dist(recv_cnt, peer_acked_cnt) == link_cfg.ack_window) begin
                note(KIND_SEND_S, '0, recv_cnt, '0);
                peer_acked_cnt = recv_cnt;
              end
              note(KIND_DATA, e.ns, '0, '0);
            end
          end
        end
      end
      CMD_RX_S: begin
        t3_idle = tmr_load(link_cfg.idle_timeout);
        void'(take_ack(e.nr));
      end
      CMD_RX_U: begin
        t3_idle = tmr_load(link_cfg.idle_timeout);
        case (e.fn)
          FN_STARTACT: begin
            if (link_cfg.is_master) begin
              close_session();
            end else begin
              stopped = 1'b0;
              note(KIND_SEND_U, '0, '0, FN_STARTCON);
              note(KIND_ACT, '0, '0, '0);
            end
          end
          FN_STARTCON: begin
            if (!link_cfg.is_master) begin
              close_session();
            end else begin
              t1_ack = '0;
              stopped = 1'b0;
              note(KIND_ACT, '0, '0, '0);
            end
          end
          FN_STOPACT: begin
            if (link_cfg.is_master) begin
              close_session();
            end else begin
              stopped = 1'b1;
              note(KIND_SEND_U, '0, '0, FN_STOPCON);
              note(KIND_DEACT, '0, '0, '0);
            end
          end
          FN_STOPCON: begin
            if (!link_cfg.is_master) begin
              close_session();
            end else begin
              stopped = 1'b1;
              note(KIND_DEACT, '0, '0, '0);
            end
          end
          FN_TESTACT: begin
            note(KIND_SEND_U, '0, '0, FN_TESTCON);
            if (!link_cfg.is_master && !test_pend) t3_idle = '0;
          end
          FN_TESTCON: begin
            if (!test_pend) begin
              close_session();
            end else begin
              t1_ack = '0;
              test_pend = 1'b0;
            end
          end
          default: begin
          end
        endcase
      end
      CMD_TX_REQ: begin
        // A 15-bit window can never pass the modulus less one, so no cap is needed.
        if ((!link_cfg.is_master && stopped) ||
            seq_dist(send_cnt, acked_cnt) >= link_cfg.send_window) begin
          note(KIND_REFUSE, '0, '0, '0);
        end else begin
          note(KIND_SEND_I, send_cnt, recv_cnt, '0);
          t1_ack = tmr_load(link_cfg.ack_timeout);
          send_cnt = send_cnt + 1'b1;
        end
      end
      CMD_TICK: begin
        // t1 first; its expiry closes and nothing else happens on that tick.
        if (tmr_due(t1_ack)) begin
          close_session();
        end else begin
          t1_ack = tmr_tick(t1_ack);
          if (tmr_due(t2_delay)) begin
            note(KIND_SEND_S, '0, recv_cnt, '0);
            peer_acked_cnt = recv_cnt;
          end
          t2_delay = tmr_tick(t2_delay);
          if (tmr_due(t3_idle)) begin
            t1_ack = tmr_load(link_cfg.ack_timeout);
            test_pend = 1'b1;
            note(KIND_SEND_U, '0, '0, FN_TESTACT);
          end
          t3_idle = tmr_tick(t3_idle);
        end
      end
      CMD_CONNECT: begin
        clear_session();
        if (link_cfg.is_master) begin
          note(KIND_SEND_U, '0, '0, FN_STARTACT);
          t1_ack = tmr_load(link_cfg.ack_timeout);
        end
      end
      default: begin
      end
    endcase
    if (event_beats.size() != 0) begin
      tail = event_beats.pop_back();
      tail.last = 1'b1;
      event_beats.push_back(tail);
    end
    foreach (event_beats[i]) awaited_beats.push_back(event_beats[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Idle pattern: mostly no gap, else short gaps, a few long ones, and now and then
  // a calm stretch with no gap at all. Side 0 is the sender, side 1 the receiver.
  // ---------------------------------------------------------------------------
  function automatic int unsigned pick_idle(int side);
    int unsigned r;
    if (calm_left[side] > 0) begin
      calm_left[side]--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm_left[side] = $urandom_range(20, 60);
      return 0;
    end
    if (r < 70) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver. The event on the port is predicted at the edge that accepts it; the
  // next one is picked after that, so a shaped frame sees the updated session.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    link_evt_t nxt;
    seq_t      span;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_event(cur_evt);
        accepted_cnt++;
      end
      // A stalled beat stays exactly as it is.
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending.size() != 0) begin
          nxt = pending.pop_front();
          if (nxt.shaped) begin
            // In-order N(S), and an N(R) that acknowledges none, some or all of
            // the frames still outstanding.
            span = seq_dist(send_cnt, acked_cnt);
            nxt.ns = recv_cnt;
            if ($urandom_range(0, 1) == 1) nxt.nr = send_cnt;
            else nxt.nr = acked_cnt + seq_t'($urandom_range(0, span));
          end
          cur_evt = nxt;
          in_cmd <= nxt.cmd;
          in_rx_send_seq <= nxt.ns;
          in_rx_recv_seq <= nxt.nr;
          in_rx_func <= nxt.fn;
          in_valid <= 1'b1;
          gap_left = pick_idle(0);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor. Each accepted result beat is checked against the oldest one
  // predicted; the receiver then decides whether to stall the next cycle.
  // ---------------------------------------------------------------------------
  function automatic void check_field(string label, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      err_cnt++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
    end
  endfunction

  always @(posedge clk) begin
    beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_beats.size() == 0) begin
        err_cnt++;
        $display("%0t ns: unexpected beat, expected none, actual kind %0d", $time, out_kind);
      end else begin
        want = awaited_beats.pop_front();
        check_field("kind", 16'(want.kind), 16'(out_kind));
        check_field("send_seq", 16'(want.send_seq), 16'(out_send_seq));
        check_field("recv_seq", 16'(want.recv_seq), 16'(out_recv_seq));
        check_field("func", 16'(want.func), 16'(out_func));
        check_field("last", 16'(want.last), 16'(out_last));
      end
    end
    if (stall_left == 0) stall_left = pick_idle(1);
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog for a block that hangs or loses beats.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  function automatic void push_evt(cmd_t cmd, seq_t ns, seq_t nr, func_t fn, bit shaped);
    link_evt_t e;
    e.cmd = cmd;
    e.ns = ns;
    e.nr = nr;
    e.fn = fn;
    e.shaped = shaped;
    pending.push_back(e);
    pushed_cnt++;
  endfunction

  // U functions are mostly the ones that suit the station's role, with some
  // wrong-role, spare and unexpected ones mixed in.
  function automatic func_t pick_u_func();
    int unsigned q;
    q = $urandom_range(0, 99);
    if (q < 15) return func_t'($urandom);
    if (link_cfg.is_master) begin
      if (q < 50) return FN_STARTCON;
      if (q < 60) return FN_STOPCON;
      if (q < 80) return FN_TESTACT;
      return FN_TESTCON;
    end
    if (q < 55) return FN_STARTACT;
    if (q < 65) return FN_STOPACT;
    if (q < 85) return FN_TESTACT;
    return FN_TESTCON;
  endfunction

  // Random traffic. Most received frames are shaped to be in order so the
  // session gets deep into its states; the rest carry fully random numbers.
  // Spare event codes go by as noise and do not count toward n.
  function automatic void add_random(int unsigned n);
    int unsigned done;
    int unsigned r;
    seq_t        ns;
    seq_t        nr;
    done = 0;
    while (done < n) begin
      r = $urandom_range(0, 99);
      ns = seq_t'($urandom);
      nr = seq_t'($urandom);
      if (r < 28) begin
        push_evt(CMD_RX_I, ns, nr, func_t'($urandom), $urandom_range(0, 9) != 0);
      end else if (r < 40) begin
        push_evt(CMD_RX_S, ns, nr, func_t'($urandom), $urandom_range(0, 6) != 0);
      end else if (r < 54) begin
        push_evt(CMD_RX_U, ns, nr, pick_u_func(), 1'b0);
      end else if (r < 74) begin
        push_evt(CMD_TX_REQ, ns, nr, func_t'($urandom), 1'b0);
      end else if (r < 94) begin
        push_evt(CMD_TICK, ns, nr, func_t'($urandom), 1'b0);
      end else if (r < 97) begin
        push_evt(CMD_CONNECT, ns, nr, func_t'($urandom), 1'b0);
      end else begin
        push_evt($urandom_range(0, 1) ? CMD_SPARE_HI : CMD_SPARE_LO, ns, nr,
                 func_t'($urandom), 1'b0);
        continue;
      end
      done++;
    end
  endfunction

  // Waits until every event has been taken and every predicted beat has come,
  // then gives a no-result event time to finish inside the block.
  task automatic wait_drained();
    while (accepted_cnt != pushed_cnt || awaited_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[CFG_DATA_W-1:0];
    case (idx)
      CFG_IS_MASTER:    link_cfg.is_master = val[0];
      CFG_ACK_TIMEOUT:  link_cfg.ack_timeout = val[TMR_W-1:0];
      CFG_ACK_DELAY:    link_cfg.ack_delay = val[TMR_W-1:0];
      CFG_IDLE_TIMEOUT: link_cfg.idle_timeout = val[TMR_W-1:0];
      CFG_SEND_WINDOW:  link_cfg.send_window = val[SEQ_W-1:0];
      CFG_ACK_WINDOW:   link_cfg.ack_window = val[SEQ_W-1:0];
      default: begin
      end
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Every phase starts from a quiet block, so the sender always pauses here
  // until all results of the previous phase are in.
  task automatic start_phase(int unsigned master, int unsigned t1, int unsigned t2,
                             int unsigned t3, int unsigned k, int unsigned w);
    wait_drained();
    write_reg(CFG_IS_MASTER, master);
    write_reg(CFG_ACK_TIMEOUT, t1);
    write_reg(CFG_ACK_DELAY, t2);
    write_reg(CFG_IDLE_TIMEOUT, t3);
    write_reg(CFG_SEND_WINDOW, k);
    write_reg(CFG_ACK_WINDOW, w);
  endtask

  initial begin
    // The mirror starts out as the block comes out of reset.
    link_cfg.is_master = 1'b0;
    link_cfg.ack_timeout = RST_ACK_TIMEOUT;
    link_cfg.ack_delay = RST_ACK_DELAY;
    link_cfg.idle_timeout = RST_IDLE_TIMEOUT;
    link_cfg.send_window = RST_SEND_WINDOW;
    link_cfg.ack_window = RST_ACK_WINDOW;
    clear_session();

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Controlled station with short timers and tiny windows, walked through
    // its corner cases by hand.
    start_phase(0, 3, 2, 4, 2, 2);
    // Stopped: an I frame is dropped and a transmit request is refused.
    push_evt(CMD_RX_I, 15'h7fff, 15'h7fff, FN_SPARE, 1'b0);
    push_evt(CMD_TX_REQ, '0, '0, '0, 1'b0);
    // A spare U function and spare event codes give nothing.
    push_evt(CMD_RX_U, '0, '0, FN_SPARE, 1'b0);
    push_evt(CMD_SPARE_LO, '0, '0, '0, 1'b0);
    push_evt(CMD_SPARE_HI, 15'h7fff, 15'h7fff, FN_SPARE, 1'b0);
    push_evt(CMD_RX_U, '0, '0, FN_STARTACT, 1'b0);
    // Two frames fill a window of two; the third request is refused.
    push_evt(CMD_TX_REQ, '0, '0, '0, 1'b0);
    push_evt(CMD_TX_REQ, '0, '0, '0, 1'b0);
    push_evt(CMD_TX_REQ, '0, '0, '0, 1'b0);
    push_evt(CMD_RX_S, '0, 15'd2, '0, 1'b0);
    // The second in-order I frame reaches the ack window and forces an S frame.
    push_evt(CMD_RX_I, 15'd0, 15'd2, '0, 1'b0);
    push_evt(CMD_RX_I, 15'd1, 15'd2, '0, 1'b0);
    push_evt(CMD_RX_U, '0, '0, FN_TESTACT, 1'b0);
    // A test confirm with no test outstanding closes.
    push_evt(CMD_RX_U, '0, '0, FN_TESTCON, 1'b0);
    // An out-of-order N(S) closes.
    push_evt(CMD_RX_U, '0, '0, FN_STARTACT, 1'b0);
    push_evt(CMD_RX_I, 15'd5, 15'd0, '0, 1'b0);
    // An N(R) beyond what was sent closes.
    push_evt(CMD_RX_U, '0, '0, FN_STARTACT, 1'b0);
    push_evt(CMD_TX_REQ, '0, '0, '0, 1'b0);
    push_evt(CMD_RX_S, '0, 15'h7fff, '0, 1'b0);
    // Receive silence: t3 runs out and a test frame goes out, then it is confirmed.
    push_evt(CMD_RX_U, '0, '0, FN_STARTACT, 1'b0);
    repeat (4) push_evt(CMD_TICK, '0, '0, '0, 1'b0);
    push_evt(CMD_RX_U, '0, '0, FN_TESTCON, 1'b0);
    push_evt(CMD_RX_U, '0, '0, FN_STOPACT, 1'b0);
    // Wrong role: a start confirm at a controlled station closes.
    push_evt(CMD_RX_U, '0, '0, FN_STARTCON, 1'b0);
    push_evt(CMD_CONNECT, '0, '0, '0, 1'b0);
    add_random(40);

    // Controlling station: connect, start, then t1 running out.
    start_phase(1, 2, 1, 3, 3, 1);
    push_evt(CMD_CONNECT, '0, '0, '0, 1'b0);
    push_evt(CMD_RX_U, '0, '0, FN_STARTCON, 1'b0);
    push_evt(CMD_TX_REQ, '0, '0, '0, 1'b0);
    push_evt(CMD_TICK, '0, '0, '0, 1'b0);
    push_evt(CMD_TICK, '0, '0, '0, 1'b0);
    push_evt(CMD_RX_U, '0, '0, FN_STOPCON, 1'b0);
    push_evt(CMD_RX_U, '0, '0, FN_STARTACT, 1'b0);
    push_evt(CMD_RX_U, '0, '0, FN_STOPACT, 1'b0);
    add_random(40);

    // Reset values of the timers and windows.
    start_phase(0, 15, 10, 20, 12, 8);
    add_random(40);

    // Largest settings: timers that never run out here and the widest windows.
    start_phase(1, 255, 255, 255, 32767, 32767);
    add_random(50);

    // Smallest settings: every I frame is acknowledged at once, one frame in flight.
    start_phase(0, 1, 1, 1, 1, 1);
    add_random(60);

    // A delayed acknowledgement loaded from zero fires on the first tick.
    start_phase(1, 4, 0, 3, 5, 3);
    add_random(60);

    start_phase(0, 6, 3, 5, 7, 4);
    add_random(40);

    wait_drained();
    if (err_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
